FILE: rtl/hsvrgb_pkg.sv
package hsvrgb_pkg;

   // field widths
   localparam int HUE_W   = 16;
   localparam int CHAN_W  = 8;
   localparam int HU_W    = 15;   // wrapped hue 0..23039
   localparam int FRAC_W  = 12;   // sector fraction 0..3839
   localparam int COMP_W  = 13;   // 3840 - fraction, 1..3840
   localparam int NUM_W   = 20;   // scaled numerators up to 255*3840
   localparam int XQ_W    = 28;   // value times numerator
   localparam int XP_W    = 16;   // value times (255 - saturation)
   localparam int QE_W    = 9;    // quotient estimate before correction
   localparam int RQ_W    = 41;   // reciprocal product for q and t
   localparam int RP_W    = 25;   // reciprocal product for p
   localparam int REM_W   = 21;

   // hue wrap constants in 1/64 degree
   localparam logic signed [HUE_W:0] TURN_POS   = 17'sd23040;
   localparam logic signed [HUE_W:0] TURN_NEG   = -17'sd23040;
   localparam logic signed [HUE_W:0] TWO_TURNS  = 17'sd46080;

   // sector boundaries
   localparam logic [HU_W-1:0] SECTOR_UNITS = 15'd3840;
   localparam logic [HU_W-1:0] BOUND_1 = 15'd3840;
   localparam logic [HU_W-1:0] BOUND_2 = 15'd7680;
   localparam logic [HU_W-1:0] BOUND_3 = 15'd11520;
   localparam logic [HU_W-1:0] BOUND_4 = 15'd15360;
   localparam logic [HU_W-1:0] BOUND_5 = 15'd19200;

   // scaling constants
   localparam logic [CHAN_W-1:0] FULL_SCALE = 8'd255;
   localparam logic [NUM_W-1:0]  DEN        = 20'd979200;   // 255 * 3840
   localparam logic [XQ_W-1:0]   HALF_DEN   = 28'd489600;
   localparam logic [XP_W-1:0]   HALF_SCALE = 16'd127;

   // floor(m / 3825) via reciprocal 2^32 / 3825, low by at most one
   localparam logic [NUM_W-1:0]  DEN_LOW     = 20'd3825;   // DEN / 256
   localparam logic [RQ_W-1:0]   RECIP_DEN   = 41'd1122867;
   // floor(n / 255) via reciprocal 2^16 / 255, low by at most one
   localparam logic [RP_W-1:0]   RECIP_SCALE = 25'd257;

   typedef enum logic [2:0] {
      SECTOR_0 = 3'd0,
      SECTOR_1 = 3'd1,
      SECTOR_2 = 3'd2,
      SECTOR_3 = 3'd3,
      SECTOR_4 = 3'd4,
      SECTOR_5 = 3'd5
   } sector_type;

   typedef struct packed {
      logic [CHAN_W-1:0] v;
      logic [CHAN_W-1:0] p;
      logic [CHAN_W-1:0] q;
      logic [CHAN_W-1:0] t;
   } levels_type;

   typedef struct packed {
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] red;
   } rgb_type;

endpackage

FILE: rtl/hsv_to_rgb_converter_top.sv
// HSV to RGB pixel converter
//
// input stream req_*: one pixel per transaction, hue in 1/64 degree (signed),
// saturation and brightness as fractions of 255. result stream rsp_*: one
// RGB pixel per transaction, in the same order.
//
// six register stages: hue wrap, sector split, scaled numerators, value
// products, reciprocal quotient estimate, correction with sector table into
// the output register. one pixel is taken every cycle while the receiver
// keeps rsp_tready high.
//
// every stage keeps a valid bit and loads when it is empty or the stage after
// it moves, so a stalled receiver holds the output register and bubbles in
// the pipe still close up; req_tready falls only once all stages are full.
// reset clears the valid bits, the pipe is then empty and ready.
module hsv_to_rgb_converter_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // hue[15:0], saturation[23:16], brightness[31:24]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // red[7:0], green[15:8], blue[23:16]
);
   import hsvrgb_pkg::*;

   localparam int STAGES = 6;

   logic [STAGES-1:0] vld_ff, vld_in, rdy;

   // stage 1 registers
   logic [HU_W-1:0]   hu1_ff, hu1_in;
   logic [CHAN_W-1:0] sat1_ff, val1_ff;
   // stage 2 registers
   sector_type        sec2_ff, sec2_in;
   logic [FRAC_W-1:0] frac2_ff, frac2_in;
   logic [CHAN_W-1:0] sat2_ff, val2_ff;
   // stage 3 registers
   sector_type        sec3_ff;
   logic [NUM_W-1:0]  qa3_ff, qa3_in, ta3_ff, ta3_in;
   logic [CHAN_W-1:0] ps3_ff, ps3_in, val3_ff;
   // stage 4 registers
   sector_type        sec4_ff;
   logic [XQ_W-1:0]   xq4_ff, xq4_in, xt4_ff, xt4_in;
   logic [XP_W-1:0]   xp4_ff, xp4_in;
   logic [CHAN_W-1:0] val4_ff;
   // stage 5 registers
   sector_type        sec5_ff;
   logic [NUM_W-1:0]  mq5_ff, mq5_in, mt5_ff, mt5_in;
   logic [XP_W-1:0]   np5_ff, np5_in;
   logic [QE_W-1:0]   eq5_ff, eq5_in, et5_ff, et5_in, ep5_ff, ep5_in;
   logic [CHAN_W-1:0] val5_ff;
   // output register
   rgb_type           rgb_ff, rgb_in;

   logic signed [HUE_W:0] hue_ext;
   logic [XQ_W-1:0]       sumq, sumt;
   logic [RQ_W-1:0]       prodq, prodt;
   logic [RP_W-1:0]       prodp;
   logic [COMP_W-1:0]     comp3;
   logic [REM_W-1:0]      remq, remt, remp;
   logic [QE_W-1:0]       fq, ft, fp;
   levels_type            levels;

   // ready chain, a stage loads when empty or when its successor moves
   always_comb begin
      rdy[STAGES-1] = !vld_ff[STAGES-1] || rsp_tready;
      for (int i = STAGES - 2; i >= 0; i--) begin
         rdy[i] = !vld_ff[i] || rdy[i+1];
      end
      vld_in = {vld_ff[STAGES-2:0], req_tvalid};
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < STAGES; i++) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (rdy[i]) begin
            vld_ff[i] <= vld_in[i];
         end
      end
   end

   assign req_tready = rdy[0];

   // stage 1: wrap hue into one turn
   always_comb begin
      hue_ext = {req_tdata[HUE_W-1], req_tdata[HUE_W-1:0]};
      if (hue_ext < TURN_NEG) begin
         hu1_in = HU_W'(hue_ext + TWO_TURNS);
      end else if (hue_ext < 17'sd0) begin
         hu1_in = HU_W'(hue_ext + TURN_POS);
      end else if (hue_ext >= TURN_POS) begin
         hu1_in = HU_W'(hue_ext - TURN_POS);
      end else begin
         hu1_in = HU_W'(hue_ext);
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         hu1_ff  <= hu1_in;
         sat1_ff <= req_tdata[23:16];
         val1_ff <= req_tdata[31:24];
      end
   end

   // stage 2: sector and fraction within the sector
   always_comb begin
      logic [HU_W-1:0] base;
      if (hu1_ff < BOUND_1) begin
         sec2_in = SECTOR_0; base = '0;
      end else if (hu1_ff < BOUND_2) begin
         sec2_in = SECTOR_1; base = BOUND_1;
      end else if (hu1_ff < BOUND_3) begin
         sec2_in = SECTOR_2; base = BOUND_2;
      end else if (hu1_ff < BOUND_4) begin
         sec2_in = SECTOR_3; base = BOUND_3;
      end else if (hu1_ff < BOUND_5) begin
         sec2_in = SECTOR_4; base = BOUND_4;
      end else begin
         sec2_in = SECTOR_5; base = BOUND_5;
      end
      frac2_in = FRAC_W'(hu1_ff - base);
   end

   always_ff @(posedge clock) begin
      if (rdy[1]) begin
         sec2_ff  <= sec2_in;
         frac2_ff <= frac2_in;
         sat2_ff  <= sat1_ff;
         val2_ff  <= val1_ff;
      end
   end

   // stage 3: numerators D - S*F, D - S*(3840 - F) and 255 - S
   always_comb begin
      comp3  = COMP_W'(SECTOR_UNITS) - {1'b0, frac2_ff};
      qa3_in = DEN - (NUM_W'(sat2_ff) * NUM_W'(frac2_ff));
      ta3_in = DEN - (NUM_W'(sat2_ff) * NUM_W'(comp3));
      ps3_in = FULL_SCALE - sat2_ff;
   end

   always_ff @(posedge clock) begin
      if (rdy[2]) begin
         sec3_ff <= sec2_ff;
         qa3_ff  <= qa3_in;
         ta3_ff  <= ta3_in;
         ps3_ff  <= ps3_in;
         val3_ff <= val2_ff;
      end
   end

   // stage 4: scale by value
   always_comb begin
      xq4_in = XQ_W'(val3_ff) * XQ_W'(qa3_ff);
      xt4_in = XQ_W'(val3_ff) * XQ_W'(ta3_ff);
      xp4_in = XP_W'(val3_ff) * XP_W'(ps3_ff);
   end

   always_ff @(posedge clock) begin
      if (rdy[3]) begin
         sec4_ff <= sec3_ff;
         xq4_ff  <= xq4_in;
         xt4_ff  <= xt4_in;
         xp4_ff  <= xp4_in;
         val4_ff <= val3_ff;
      end
   end

   // stage 5: add half divisor, quotient estimate by reciprocal
   always_comb begin
      sumq   = xq4_ff + HALF_DEN;
      sumt   = xt4_ff + HALF_DEN;
      mq5_in = sumq[XQ_W-1:8];
      mt5_in = sumt[XQ_W-1:8];
      prodq  = RQ_W'(mq5_in) * RECIP_DEN;
      prodt  = RQ_W'(mt5_in) * RECIP_DEN;
      eq5_in = prodq[RQ_W-1:32];
      et5_in = prodt[RQ_W-1:32];
      np5_in = xp4_ff + HALF_SCALE;
      prodp  = RP_W'(np5_in) * RECIP_SCALE;
      ep5_in = prodp[RP_W-1:16];
   end

   always_ff @(posedge clock) begin
      if (rdy[4]) begin
         sec5_ff <= sec4_ff;
         mq5_ff  <= mq5_in;
         mt5_ff  <= mt5_in;
         np5_ff  <= np5_in;
         eq5_ff  <= eq5_in;
         et5_ff  <= et5_in;
         ep5_ff  <= ep5_in;
         val5_ff <= val4_ff;
      end
   end

   // stage 6: one-step correction of each estimate
   always_comb begin
      remq = REM_W'(mq5_ff) - REM_W'(eq5_ff) * REM_W'(DEN_LOW);
      remt = REM_W'(mt5_ff) - REM_W'(et5_ff) * REM_W'(DEN_LOW);
      remp = REM_W'(np5_ff) - REM_W'(ep5_ff) * REM_W'(FULL_SCALE);
      fq   = (remq >= REM_W'(DEN_LOW))    ? eq5_ff + 1'b1 : eq5_ff;
      ft   = (remt >= REM_W'(DEN_LOW))    ? et5_ff + 1'b1 : et5_ff;
      fp   = (remp >= REM_W'(FULL_SCALE)) ? ep5_ff + 1'b1 : ep5_ff;
      // zero saturation makes p, q and t equal the value, so grey needs no bypass
      levels.v = val5_ff;
      levels.p = fp[CHAN_W-1:0];
      levels.q = fq[CHAN_W-1:0];
      levels.t = ft[CHAN_W-1:0];
   end

   hsvrgb_sector_map u_sector_map (
      .sector (sec5_ff),
      .levels (levels),
      .rgb    (rgb_in)
   );

   always_ff @(posedge clock) begin
      if (rdy[5]) begin
         rgb_ff <= rgb_in;
      end
   end

   assign rsp_tvalid = vld_ff[STAGES-1];
   assign rsp_tdata  = rgb_ff;

   // an empty output register must let the whole pipe take a pixel
   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled while output register empty");

   // reciprocal estimates may be low by one at most
   a_q_estimate: assert property (@(posedge clock) disable iff (reset)
      vld_ff[4] |-> (remq < 2 * REM_W'(DEN_LOW)) && (remt < 2 * REM_W'(DEN_LOW)))
      else $error("q or t quotient estimate out of range");

   a_p_estimate: assert property (@(posedge clock) disable iff (reset)
      vld_ff[4] |-> remp < 2 * REM_W'(FULL_SCALE))
      else $error("p quotient estimate out of range");

endmodule

FILE: rtl/hsvrgb_sector_map.sv
module hsvrgb_sector_map (
   input  hsvrgb_pkg::sector_type sector,
   input  hsvrgb_pkg::levels_type levels,
   output hsvrgb_pkg::rgb_type    rgb
);
   import hsvrgb_pkg::*;

   // standard sector table
   always_comb begin
      unique case (sector)
         SECTOR_0: begin
            rgb.red = levels.v; rgb.green = levels.t; rgb.blue = levels.p;
         end
         SECTOR_1: begin
            rgb.red = levels.q; rgb.green = levels.v; rgb.blue = levels.p;
         end
         SECTOR_2: begin
            rgb.red = levels.p; rgb.green = levels.v; rgb.blue = levels.t;
         end
         SECTOR_3: begin
            rgb.red = levels.p; rgb.green = levels.q; rgb.blue = levels.v;
         end
         SECTOR_4: begin
            rgb.red = levels.t; rgb.green = levels.p; rgb.blue = levels.v;
         end
         default: begin
            rgb.red = levels.v; rgb.green = levels.p; rgb.blue = levels.q;
         end
      endcase
   end

endmodule
